[rtl/sics_pkg.sv]
// Shared constants, types and arithmetic helpers of the incomplete Cholesky sweep block.
package sics_pkg;

    localparam int ROWS    = 1024;
    localparam int ENTRIES = 4096;
    localparam int FRAC    = 20;

    localparam int PTR_W  = 13;               // row pointers and merge pointers
    localparam int RS_AW  = $clog2(ROWS + 1); // row start store address
    localparam int EA_W   = $clog2(ENTRIES);  // entry slot
    localparam int COL_W  = 10;
    localparam int ROW_W  = 10;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TERM_W = SUM_W - FRAC;
    localparam int ACC_W  = 58;
    localparam int SQ_W   = VAL_W + FRAC;
    localparam int QCNT_W = 5;

    localparam logic [1:0] MODE_ROW_START = 2'd0;
    localparam logic [1:0] MODE_ENTRY     = 2'd1;
    localparam logic [1:0] MODE_UPDATE    = 2'd2;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_LOADED   = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_NO_MATCH = 2'd3;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_RS   = 16'h0002,
        S_MRD  = 16'h0004,
        S_MCMP = 16'h0008,
        S_MUL  = 16'h0010,
        S_SUM  = 16'h0020,
        S_TERM = 16'h0040,
        S_FIN  = 16'h0080,
        S_DEN  = 16'h0100,
        S_DSUM = 16'h0200,
        S_NUM  = 16'h0400,
        S_NSUM = 16'h0800,
        S_DSET = 16'h1000,
        S_DIV  = 16'h2000,
        S_SQRT = 16'h4000,
        S_DONE = 16'h8000
    } state_t;

    // row bound clamped to the entry count
    function automatic logic [PTR_W-1:0] clamp_bound(input logic [PTR_W-1:0] v);
        clamp_bound = (v > PTR_W'(ENTRIES)) ? PTR_W'(ENTRIES) : v;
    endfunction

    // exact sum truncated toward zero to Q25.20
    function automatic logic signed [TERM_W-1:0] trunc_q(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] b;
        b = s + (s[SUM_W-1] ? SUM_W'((1 << FRAC) - 1) : SUM_W'(0));
        trunc_q = b[SUM_W-1:FRAC];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_q(input logic signed [ACC_W-1:0] a);
        if (!a[ACC_W-1] && (|a[ACC_W-2:VAL_W-1]))
            sat_q = {1'b0, {(VAL_W-1){1'b1}}};
        else if (a[ACC_W-1] && !(&a[ACC_W-2:VAL_W-1]))
            sat_q = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_q = a[VAL_W-1:0];
    endfunction

endpackage

[rtl/sparse_incomplete_cholesky_sweep.sv]
// Top level: CSR stores, row merge, product accumulation, square root and complex divide.
//
// Input channel item_valid/item_stall carries one word per item: a row start load,
// an entry load (column and value) or an update of one nonzero (row_index, col_index).
// Output channel result_valid/result_stall returns exactly one word per item:
// the slot written, the new value and a status code.
// Loads go through the result register to the output register. An update reads four
// row bounds, then walks both rows with four products per matching pair, all through
// the two read ports of the column and value memories and one shared 32x32
// multiplier. It ends with a bit-serial square root on the diagonal, or the divisor
// and numerator products and two restoring divisions below it, unless the walk did
// not end on a match or the divisor is zero. One item is in work at a time;
// item_stall is high from acceptance until the result has moved into the output register.
// The output register holds a stalled word unchanged; the next item can be
// accepted and worked on while that word waits.
// Reset clears control state only; the stores hold nothing defined until loaded.
module sparse_incomplete_cholesky_sweep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          mode,
    input  logic [sics_pkg::PTR_W-1:0]          address,
    input  logic [sics_pkg::PTR_W-1:0]          row_pointer,
    input  logic [sics_pkg::COL_W-1:0]          col_index,
    input  logic [sics_pkg::ROW_W-1:0]          row_index,
    input  logic signed [sics_pkg::VAL_W-1:0]   value_real,
    input  logic signed [sics_pkg::VAL_W-1:0]   value_imag,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [sics_pkg::EA_W-1:0]           entry_slot,
    output logic signed [sics_pkg::VAL_W-1:0]   new_real,
    output logic signed [sics_pkg::VAL_W-1:0]   new_imag,
    output logic [1:0]                          status
);
    import sics_pkg::*;

    // memories
    logic [PTR_W-1:0]   rs_mem  [0:ROWS];
    logic [COL_W-1:0]   col_mem [0:ENTRIES-1];
    logic [2*VAL_W-1:0] val_mem [0:ENTRIES-1];

    logic [RS_AW-1:0]   rs_raddr;
    logic [PTR_W-1:0]   rs_q;
    logic [COL_W-1:0]   col_a_q, col_b_q;
    logic [2*VAL_W-1:0] val_a_q, val_b_q;
    logic               accept, rs_we, col_we, wb_we, val_we;
    logic [EA_W-1:0]    val_waddr;
    logic [2*VAL_W-1:0] val_wdata, wb_data;

    // control registers
    state_t             state_reg, state_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               last_match_reg, last_match_next;
    logic               div_sel_reg, div_sel_next;
    logic               out_valid_reg, out_valid_next;

    // datapath registers
    logic [ROW_W-1:0]          ri_reg, ri_next;
    logic [COL_W-1:0]          ci_reg, ci_next;
    logic [PTR_W-1:0]          il_reg, il_next, ie_reg, ie_next;
    logic [PTR_W-1:0]          iu_reg, iu_next, iu_end_reg, iu_end_next;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic signed [TERM_W-1:0]  pend_re_reg, pend_re_next, pend_im_reg, pend_im_next;
    logic signed [VAL_W-1:0]   ar_reg, ar_next, ai_reg, ai_next;
    logic signed [VAL_W-1:0]   br_reg, br_next, bi_reg, bi_next;
    logic signed [VAL_W-1:0]   sr_reg, sr_next, si_reg, si_next;
    logic [EA_W-1:0]           slot_reg, slot_next;
    logic signed [PROD_W-1:0]  p_reg [0:3];
    logic signed [PROD_W-1:0]  p_next [0:3];
    logic signed [SUM_W-1:0]   s_re_reg, s_re_next, s_im_reg, s_im_next;
    logic [PROD_W-1:0]         den_reg, den_next;
    logic [PROD_W+FRAC-1:0]    nrem_reg, nrem_next;
    logic [PROD_W+VAL_W-2:0]   dsh_reg, dsh_next;
    logic [VAL_W-1:0]          q_reg, q_next;
    logic                      neg_reg, neg_next, ovf_reg, ovf_next;
    logic signed [VAL_W-1:0]   nr_reg, nr_next;
    logic [SQ_W-1:0]           sq_x_reg, sq_x_next, sq_r_reg, sq_r_next;
    logic [SQ_W-1:0]           sq_bit_reg, sq_bit_next;
    logic [EA_W-1:0]           res_slot_reg, res_slot_next;
    logic signed [VAL_W-1:0]   res_re_reg, res_re_next, res_im_reg, res_im_next;
    logic [1:0]                res_status_reg, res_status_next;
    logic [EA_W-1:0]           out_slot_reg, out_slot_next;
    logic signed [VAL_W-1:0]   out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic [1:0]                out_status_reg, out_status_next;

    // shared multiplier
    logic signed [VAL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // combinational helpers
    logic signed [VAL_W-1:0]   sat_re, sat_im;
    logic [VAL_W-1:0]          abs_re;
    logic [PROD_W-1:0]         den_sum;
    logic signed [SUM_W-1:0]   num;
    logic [PROD_W-1:0]         num_mag;
    logic                      div_ge;
    logic [VAL_W-1:0]          qv, lim, qs;
    logic signed [VAL_W-1:0]   qres;
    logic [SQ_W:0]             sq_t;
    logic                      sq_ge;
    logic [SQ_W-1:0]           sq_r_new;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign entry_slot   = out_slot_reg;
    assign new_real     = out_re_reg;
    assign new_imag     = out_im_reg;
    assign status       = out_status_reg;

    assign rs_we     = accept && (mode == MODE_ROW_START) && (address <= PTR_W'(ROWS));
    assign col_we    = accept && (mode == MODE_ENTRY) && (address < PTR_W'(ENTRIES));
    assign val_we    = col_we || wb_we;
    assign val_waddr = wb_we ? slot_reg : address[EA_W-1:0];
    assign val_wdata = wb_we ? wb_data : {value_real, value_imag};

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    rs_raddr = RS_AW'(ri_reg);
            2'd1:    rs_raddr = RS_AW'(ri_reg) + RS_AW'(1);
            2'd2:    rs_raddr = RS_AW'(ci_reg);
            default: rs_raddr = RS_AW'(ci_reg) + RS_AW'(1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[address[RS_AW-1:0]] <= row_pointer;
        rs_q <= rs_mem[rs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[address[EA_W-1:0]] <= col_index;
        col_a_q <= col_mem[il_reg[EA_W-1:0]];
        col_b_q <= col_mem[iu_reg[EA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_waddr] <= val_wdata;
        val_a_q <= val_mem[il_reg[EA_W-1:0]];
        val_b_q <= val_mem[iu_reg[EA_W-1:0]];
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = ar_reg;
        mul_b = br_reg;
        if (state_reg == S_MUL)
        begin
            case (cnt_reg[1:0])
                2'd0:    begin mul_a = ar_reg; mul_b = br_reg; end
                2'd1:    begin mul_a = ai_reg; mul_b = bi_reg; end
                2'd2:    begin mul_a = ar_reg; mul_b = bi_reg; end
                default: begin mul_a = ai_reg; mul_b = br_reg; end
            endcase
        end
        else if (state_reg == S_DEN)
        begin
            mul_a = cnt_reg[0] ? bi_reg : br_reg;
            mul_b = mul_a;
        end
        else
        begin
            case (cnt_reg[1:0])
                2'd0:    begin mul_a = sr_reg; mul_b = br_reg; end
                2'd1:    begin mul_a = si_reg; mul_b = bi_reg; end
                2'd2:    begin mul_a = si_reg; mul_b = br_reg; end
                default: begin mul_a = sr_reg; mul_b = bi_reg; end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    assign sat_re  = sat_q(acc_re_reg);
    assign sat_im  = sat_q(acc_im_reg);
    assign abs_re  = sat_re[VAL_W-1] ? VAL_W'(-sat_re) : sat_re;
    assign den_sum = p_reg[0] + p_reg[1];
    assign num     = div_sel_reg ? s_im_reg : s_re_reg;
    assign num_mag = num[SUM_W-1] ? PROD_W'(-num) : num[PROD_W-1:0];

    assign div_ge = {{(PROD_W+VAL_W-1-PROD_W-FRAC){1'b0}}, nrem_reg} >= dsh_reg;
    assign qv     = q_reg | (div_ge ? (VAL_W'(1) << cnt_reg) : VAL_W'(0));
    assign lim    = neg_reg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    assign qs     = (ovf_reg || (qv > lim)) ? lim : qv;
    assign qres   = neg_reg ? VAL_W'(-qs) : qs;

    assign sq_t     = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};
    assign sq_ge    = {1'b0, sq_x_reg} >= sq_t;
    assign sq_r_new = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        last_match_next = last_match_reg;
        div_sel_next    = div_sel_reg;
        out_valid_next  = out_valid_reg;
        ri_next         = ri_reg;
        ci_next         = ci_reg;
        il_next         = il_reg;
        ie_next         = ie_reg;
        iu_next         = iu_reg;
        iu_end_next     = iu_end_reg;
        acc_re_next     = acc_re_reg;
        acc_im_next     = acc_im_reg;
        pend_re_next    = pend_re_reg;
        pend_im_next    = pend_im_reg;
        ar_next         = ar_reg;
        ai_next         = ai_reg;
        br_next         = br_reg;
        bi_next         = bi_reg;
        sr_next         = sr_reg;
        si_next         = si_reg;
        slot_next       = slot_reg;
        for (int k = 0; k < 4; k++)
            p_next[k] = p_reg[k];
        s_re_next       = s_re_reg;
        s_im_next       = s_im_reg;
        den_next        = den_reg;
        nrem_next       = nrem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        neg_next        = neg_reg;
        ovf_next        = ovf_reg;
        nr_next         = nr_reg;
        sq_x_next       = sq_x_reg;
        sq_r_next       = sq_r_reg;
        sq_bit_next     = sq_bit_reg;
        res_slot_next   = res_slot_reg;
        res_re_next     = res_re_reg;
        res_im_next     = res_im_reg;
        res_status_next = res_status_reg;
        out_slot_next   = out_slot_reg;
        out_re_next     = out_re_reg;
        out_im_next     = out_im_reg;
        out_status_next = out_status_reg;
        wb_we           = 1'b0;
        wb_data         = {nr_reg, qres};

        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ri_next         = row_index;
                    ci_next         = col_index;
                    acc_re_next     = ACC_W'(value_real);
                    acc_im_next     = ACC_W'(value_imag);
                    pend_valid_next = 1'b0;
                    last_match_next = 1'b0;
                    cnt_next        = '0;
                    if (mode == MODE_UPDATE)
                        state_next = S_RS;
                    else
                    begin
                        res_slot_next   = '0;
                        res_re_next     = '0;
                        res_im_next     = '0;
                        res_status_next = ST_LOADED;
                        state_next      = S_DONE;
                    end
                end
            end
            S_RS:
            begin
                cnt_next = cnt_reg + QCNT_W'(1);
                case (cnt_reg[2:0])
                    3'd1:    il_next = clamp_bound(rs_q);
                    3'd2:    ie_next = clamp_bound(rs_q);
                    3'd3:    iu_next = clamp_bound(rs_q);
                    3'd4:
                    begin
                        iu_end_next = clamp_bound(rs_q);
                        state_next  = S_MRD;
                    end
                    default: ;
                endcase
            end
            S_MRD:
            begin
                if ((il_reg < ie_reg) && (iu_reg < iu_end_reg))
                    state_next = S_MCMP;
                else
                    state_next = S_FIN;
            end
            S_MCMP:
            begin
                if (col_a_q < col_b_q)
                begin
                    il_next         = il_reg + PTR_W'(1);
                    last_match_next = 1'b0;
                    state_next      = S_MRD;
                end
                else if (col_b_q < col_a_q)
                begin
                    iu_next         = iu_reg + PTR_W'(1);
                    last_match_next = 1'b0;
                    state_next      = S_MRD;
                end
                else
                begin
                    if (pend_valid_reg)
                    begin
                        acc_re_next = acc_re_reg - ACC_W'(pend_re_reg);
                        acc_im_next = acc_im_reg - ACC_W'(pend_im_reg);
                    end
                    ar_next         = val_a_q[2*VAL_W-1:VAL_W];
                    ai_next         = val_a_q[VAL_W-1:0];
                    br_next         = val_b_q[2*VAL_W-1:VAL_W];
                    bi_next         = val_b_q[VAL_W-1:0];
                    slot_next       = il_reg[EA_W-1:0];
                    il_next         = il_reg + PTR_W'(1);
                    iu_next         = iu_reg + PTR_W'(1);
                    last_match_next = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_MUL;
                end
            end
            S_MUL:
            begin
                p_next[cnt_reg[1:0]] = mul_p;
                cnt_next = cnt_reg + QCNT_W'(1);
                if (cnt_reg[1:0] == 2'd3)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                // re: ar*br - ai*bi, im: ar*bi + ai*br
                s_re_next  = SUM_W'(p_reg[0]) - SUM_W'(p_reg[1]);
                s_im_next  = SUM_W'(p_reg[2]) + SUM_W'(p_reg[3]);
                state_next = S_TERM;
            end
            S_TERM:
            begin
                pend_re_next    = trunc_q(s_re_reg);
                pend_im_next    = trunc_q(s_im_reg);
                pend_valid_next = 1'b1;
                state_next      = S_MRD;
            end
            S_FIN:
            begin
                sr_next  = sat_re;
                si_next  = sat_im;
                cnt_next = '0;
                if (!last_match_reg)
                begin
                    res_slot_next   = '0;
                    res_re_next     = '0;
                    res_im_next     = '0;
                    res_status_next = ST_NO_MATCH;
                    state_next      = S_DONE;
                end
                else if (ri_reg == ci_reg)
                begin
                    sq_x_next   = {abs_re, {FRAC{1'b0}}};
                    sq_r_next   = '0;
                    sq_bit_next = SQ_W'(1) << (SQ_W - 2);
                    cnt_next    = QCNT_W'(SQ_W / 2 - 1);
                    state_next  = S_SQRT;
                end
                else
                    state_next = S_DEN;
            end
            S_DEN:
            begin
                p_next[cnt_reg[1:0]] = mul_p;
                cnt_next = cnt_reg + QCNT_W'(1);
                if (cnt_reg[0])
                    state_next = S_DSUM;
            end
            S_DSUM:
            begin
                den_next = den_sum;
                cnt_next = '0;
                if (den_sum == '0)
                begin
                    res_slot_next   = slot_reg;
                    res_re_next     = '0;
                    res_im_next     = '0;
                    res_status_next = ST_DIV_ZERO;
                    state_next      = S_DONE;
                end
                else
                    state_next = S_NUM;
            end
            S_NUM:
            begin
                p_next[cnt_reg[1:0]] = mul_p;
                cnt_next = cnt_reg + QCNT_W'(1);
                if (cnt_reg[1:0] == 2'd3)
                    state_next = S_NSUM;
            end
            S_NSUM:
            begin
                // s * conj(d): re sr*dr + si*di, im si*dr - sr*di
                s_re_next    = SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]);
                s_im_next    = SUM_W'(p_reg[2]) - SUM_W'(p_reg[3]);
                div_sel_next = 1'b0;
                state_next   = S_DSET;
            end
            S_DSET:
            begin
                neg_next   = num[SUM_W-1];
                // quotient needs more than 32 bits: saturate
                ovf_next   = {{FRAC{1'b0}}, num_mag} >= {den_reg, {FRAC{1'b0}}} >> (FRAC - 12);
                nrem_next  = {num_mag, {FRAC{1'b0}}};
                dsh_next   = {den_reg, {(VAL_W-1){1'b0}}};
                q_next     = '0;
                cnt_next   = QCNT_W'(VAL_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_ge)
                    nrem_next = nrem_reg - dsh_reg[PROD_W+FRAC-1:0];
                q_next   = qv;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - QCNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (!div_sel_reg)
                    begin
                        nr_next      = qres;
                        div_sel_next = 1'b1;
                        state_next   = S_DSET;
                    end
                    else
                    begin
                        wb_we           = 1'b1;
                        wb_data         = {nr_reg, qres};
                        res_slot_next   = slot_reg;
                        res_re_next     = nr_reg;
                        res_im_next     = qres;
                        res_status_next = ST_UPDATED;
                        state_next      = S_DONE;
                    end
                end
            end
            S_SQRT:
            begin
                if (sq_ge)
                    sq_x_next = sq_x_reg - sq_t[SQ_W-1:0];
                sq_r_next   = sq_r_new;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg - QCNT_W'(1);
                if (cnt_reg == '0)
                begin
                    wb_we           = 1'b1;
                    wb_data         = {sq_r_new[VAL_W-1:0], {VAL_W{1'b0}}};
                    res_slot_next   = slot_reg;
                    res_re_next     = sq_r_new[VAL_W-1:0];
                    res_im_next     = '0;
                    res_status_next = ST_UPDATED;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_re_next     = res_re_reg;
                    out_im_next     = res_im_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            last_match_reg <= 1'b0;
            div_sel_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            last_match_reg <= last_match_next;
            div_sel_reg    <= div_sel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ri_reg         <= ri_next;
        ci_reg         <= ci_next;
        il_reg         <= il_next;
        ie_reg         <= ie_next;
        iu_reg         <= iu_next;
        iu_end_reg     <= iu_end_next;
        acc_re_reg     <= acc_re_next;
        acc_im_reg     <= acc_im_next;
        pend_re_reg    <= pend_re_next;
        pend_im_reg    <= pend_im_next;
        ar_reg         <= ar_next;
        ai_reg         <= ai_next;
        br_reg         <= br_next;
        bi_reg         <= bi_next;
        sr_reg         <= sr_next;
        si_reg         <= si_next;
        slot_reg       <= slot_next;
        for (int k = 0; k < 4; k++)
            p_reg[k] <= p_next[k];
        s_re_reg       <= s_re_next;
        s_im_reg       <= s_im_next;
        den_reg        <= den_next;
        nrem_reg       <= nrem_next;
        dsh_reg        <= dsh_next;
        q_reg          <= q_next;
        neg_reg        <= neg_next;
        ovf_reg        <= ovf_next;
        nr_reg         <= nr_next;
        sq_x_reg       <= sq_x_next;
        sq_r_reg       <= sq_r_next;
        sq_bit_reg     <= sq_bit_next;
        res_slot_reg   <= res_slot_next;
        res_re_reg     <= res_re_next;
        res_im_reg     <= res_im_next;
        res_status_reg <= res_status_next;
        out_slot_reg   <= out_slot_next;
        out_re_reg     <= out_re_next;
        out_im_reg     <= out_im_next;
        out_status_reg <= out_status_next;
    end

endmodule

[verif/sics_checker.sv]
// Channel monitor, sparse-factor predictor and result comparison for the sweep block.
`timescale 1ns / 100ps

module sics_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic [1:0]                          mode,
    input  logic [sics_pkg::PTR_W-1:0]          address,
    input  logic [sics_pkg::PTR_W-1:0]          row_pointer,
    input  logic [sics_pkg::COL_W-1:0]          col_index,
    input  logic [sics_pkg::ROW_W-1:0]          row_index,
    input  logic signed [sics_pkg::VAL_W-1:0]   value_real,
    input  logic signed [sics_pkg::VAL_W-1:0]   value_imag,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic [sics_pkg::EA_W-1:0]           entry_slot,
    input  logic signed [sics_pkg::VAL_W-1:0]   new_real,
    input  logic signed [sics_pkg::VAL_W-1:0]   new_imag,
    input  logic [1:0]                          status,
    output int                                  fail_count,
    output int                                  words_waiting,
    output int                                  words_checked
);
    import sics_pkg::*;

    typedef struct packed {
        logic [EA_W-1:0]         slot;
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
        logic [1:0]              st;
    } factor_word_t;

    typedef logic signed [79:0] wide_t;

    logic [PTR_W-1:0]        row_starts [0:ROWS];
    logic [COL_W-1:0]        entry_cols [0:ENTRIES-1];
    logic signed [VAL_W-1:0] entry_re   [0:ENTRIES-1];
    logic signed [VAL_W-1:0] entry_im   [0:ENTRIES-1];

    factor_word_t expected_words [$];

    initial
    begin
        for (int k = 0; k <= ROWS; k++)
            row_starts[k] = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            entry_cols[k] = '0;
            entry_re[k]   = '0;
            entry_im[k]   = '0;
        end
        fail_count    = 0;
        words_checked = 0;
    end

    assign words_waiting = expected_words.size();

    function automatic int clamp_start(input logic [PTR_W-1:0] v);
        return (int'(v) > ENTRIES) ? ENTRIES : int'(v);
    endfunction

    // product sum truncated toward zero to Q25.20
    function automatic wide_t to_q(input wide_t s);
        wide_t m;
        m = (s < 0) ? -s : s;
        m = m >>> FRAC;
        return (s < 0) ? -m : m;
    endfunction

    function automatic logic signed [VAL_W-1:0] clip32(input wide_t s);
        if (s > 80'sd2147483647)
            return 32'sh7FFFFFFF;
        if (s < -80'sd2147483648)
            return 32'sh80000000;
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [31:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 26; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] q_quot(input wide_t num, input wide_t den);
        logic [127:0] m;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        neg = num < 0;
        m   = neg ? 128'(-num) : 128'(num);
        q   = (m << FRAC) / 128'(den);
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (q > lim)
            q = lim;
        return neg ? -q[VAL_W-1:0] : q[VAL_W-1:0];
    endfunction

    function automatic factor_word_t sweep_update(input logic [ROW_W-1:0] ri,
                                                  input logic [COL_W-1:0] cj,
                                                  input logic signed [VAL_W-1:0] vr,
                                                  input logic signed [VAL_W-1:0] vi);
        factor_word_t w;
        int    il, ie, iu, je, slot, dslot;
        wide_t acc_r, acc_i, pr, pi, ar, ai, br, bi, dr, di, den, sr, si;
        logic  pending, last_match;
        w = '0;
        w.st = ST_NO_MATCH;
        acc_r = vr;
        acc_i = vi;
        pr = 0;
        pi = 0;
        pending = 0;
        last_match = 0;
        il = clamp_start(row_starts[ri]);
        ie = clamp_start(row_starts[ri + 1]);
        iu = clamp_start(row_starts[cj]);
        je = clamp_start(row_starts[cj + 1]);
        while (il < ie && iu < je)
        begin
            last_match = 0;
            if (entry_cols[il] < entry_cols[iu])
                il++;
            else if (entry_cols[iu] < entry_cols[il])
                iu++;
            else
            begin
                ar = entry_re[il];
                ai = entry_im[il];
                br = entry_re[iu];
                bi = entry_im[iu];
                // the previous match's product is only applied once a later match exists
                if (pending)
                begin
                    acc_r -= pr;
                    acc_i -= pi;
                end
                pr = to_q(ar * br - ai * bi);
                pi = to_q(ar * bi + ai * br);
                pending = 1;
                last_match = 1;
                il++;
                iu++;
            end
        end
        if (!last_match)
            return w;
        slot  = il - 1;
        dslot = iu - 1;
        sr = clip32(acc_r);
        si = clip32(acc_i);
        if (ri == cj)
        begin
            w.re = root_floor(64'((sr < 0) ? -sr : sr) << FRAC);
            w.im = '0;
        end
        else
        begin
            dr  = entry_re[dslot];
            di  = entry_im[dslot];
            den = dr * dr + di * di;
            w.slot = slot[EA_W-1:0];
            if (den == 0)
            begin
                w.st = ST_DIV_ZERO;
                return w;
            end
            w.re = q_quot(sr * dr + si * di, den);
            w.im = q_quot(si * dr - sr * di, den);
        end
        entry_re[slot] = w.re;
        entry_im[slot] = w.im;
        w.slot = slot[EA_W-1:0];
        w.st   = ST_UPDATED;
        return w;
    endfunction

    always @(posedge clk)
    begin
        factor_word_t w;
        factor_word_t got;
        if (rst_n && item_valid && !item_stall)
        begin
            w = '0;
            w.st = ST_LOADED;
            case (mode)
                MODE_ROW_START:
                    if (int'(address) <= ROWS)
                        row_starts[address[RS_AW-1:0]] = row_pointer;
                MODE_ENTRY:
                    if (int'(address) < ENTRIES)
                    begin
                        entry_cols[address[EA_W-1:0]] = col_index;
                        entry_re[address[EA_W-1:0]]   = value_real;
                        entry_im[address[EA_W-1:0]]   = value_imag;
                    end
                MODE_UPDATE:
                    w = sweep_update(row_index, col_index, value_real, value_imag);
                default: ;
            endcase
            expected_words.push_back(w);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{entry_slot, new_real, new_imag, status};
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: slot %0d status %0d",
                       entry_slot, status);
                fail_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                words_checked++;
                if (got.slot !== w.slot)
                begin
                    $error("entry_slot: expected %0d, got %0d", w.slot, got.slot);
                    fail_count++;
                end
                if (got.re !== w.re)
                begin
                    $error("new_real: expected %0d, got %0d", w.re, got.re);
                    fail_count++;
                end
                if (got.im !== w.im)
                begin
                    $error("new_imag: expected %0d, got %0d", w.im, got.im);
                    fail_count++;
                end
                if (got.st !== w.st)
                begin
                    $error("status: expected %0d, got %0d", w.st, got.st);
                    fail_count++;
                end
            end
        end
    end

endmodule

[verif/tb.sv]
// Testbench top: clock, reset, CSR stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
    import sics_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    logic [1:0]              mode;
    logic [PTR_W-1:0]        address;
    logic [PTR_W-1:0]        row_pointer;
    logic [COL_W-1:0]        col_index;
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] value_real;
    logic signed [VAL_W-1:0] value_imag;
    logic                    result_valid;
    logic                    result_stall;
    logic [EA_W-1:0]         entry_slot;
    logic signed [VAL_W-1:0] new_real;
    logic signed [VAL_W-1:0] new_imag;
    logic [1:0]              status;

    int fail_count, words_waiting, words_checked;
    int tx_idle, rx_idle, hold_left, quiet_cycles;
    int words_sent, updates_sent;

    // what the generator knows is written, so no update reads an unwritten slot
    logic [PTR_W-1:0] start_shadow [0:ROWS];
    bit               start_known  [0:ROWS];
    bit               entry_known  [0:ENTRIES-1];

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;

    // unused mode code: the block answers it like a load and changes nothing
    localparam logic [1:0] MODE_SPARE = 2'd3;

    sparse_incomplete_cholesky_sweep DUT (.*);

    sics_checker scoreboard (.*);

    initial
        clk = 0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < rx_idle);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(input logic [1:0] m, input logic [PTR_W-1:0] a,
                        input logic [PTR_W-1:0] p, input logic [COL_W-1:0] c,
                        input logic [ROW_W-1:0] r, input logic [31:0] vr,
                        input logic [31:0] vi);
        while ($urandom_range(99) < tx_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        mode        <= m;
        address     <= a;
        row_pointer <= p;
        col_index   <= c;
        row_index   <= r;
        value_real  <= vr;
        value_imag  <= vi;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
            2: return ($urandom_range(1)) ? 32'h0010_0000 : 32'hFFF0_0000;
            3: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    task automatic load_start(input int r, input logic [PTR_W-1:0] p);
        send(MODE_ROW_START, PTR_W'(r), p, COL_W'($urandom), ROW_W'($urandom),
             $urandom, $urandom);
        if (r <= ROWS)
        begin
            start_shadow[r] = p;
            start_known[r]  = 1;
        end
    endtask

    task automatic load_entry(input int s, input int c, input logic [31:0] vr,
                              input logic [31:0] vi);
        send(MODE_ENTRY, PTR_W'(s), PTR_W'($urandom), COL_W'(c), ROW_W'($urandom), vr, vi);
        if (s < ENTRIES)
            entry_known[s] = 1;
    endtask

    function automatic bit row_readable(input int r);
        int lo, hi;
        if (!start_known[r] || !start_known[r + 1])
            return 0;
        lo = (start_shadow[r] > ENTRIES) ? ENTRIES : int'(start_shadow[r]);
        hi = (start_shadow[r + 1] > ENTRIES) ? ENTRIES : int'(start_shadow[r + 1]);
        for (int k = lo; k < hi; k++)
            if (!entry_known[k])
                return 0;
        return 1;
    endfunction

    task automatic update(input int i, input int j, input logic [31:0] vr,
                          input logic [31:0] vi);
        if (row_readable(i) && row_readable(j))
        begin
            send(MODE_UPDATE, PTR_W'($urandom), PTR_W'($urandom), COL_W'(j), ROW_W'(i),
                 vr, vi);
            updates_sent++;
        end
    endtask

    // a small lower-triangular block: rows with sorted columns, diagonal usually present and always last
    task automatic build_block();
        int base, nrows, slot, i, j;
        base  = $urandom_range(0, ROWS - 5);
        nrows = $urandom_range(1, 4);
        slot  = ($urandom_range(3) == 0) ? $urandom_range(ENTRIES - 20, ENTRIES - 17)
                                         : $urandom_range(0, ENTRIES - 20);
        for (int r = 0; r < nrows; r++)
        begin
            load_start(base + r, PTR_W'(slot));
            for (int c = base; c <= base + r; c++)
                if ($urandom_range(99) < ((c == base + r) ? 90 : 50))
                begin
                    load_entry(slot, c, pick_value(), pick_value());
                    slot++;
                end
        end
        load_start(base + nrows, PTR_W'(slot));
        repeat ($urandom_range(2, 6))
        begin
            i = base + $urandom_range(0, nrows - 1);
            j = $urandom_range(base, i);
            update(i, j, pick_value(), pick_value());
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(4))
            0: send(MODE_SPARE, PTR_W'($urandom), PTR_W'($urandom), COL_W'($urandom),
                    ROW_W'($urandom), $urandom, $urandom);
            1: send(MODE_ROW_START, PTR_W'($urandom_range(ROWS + 1, 8191)), PTR_W'($urandom),
                    COL_W'($urandom), ROW_W'($urandom), $urandom, $urandom);
            2: send(MODE_ENTRY, PTR_W'($urandom_range(ENTRIES, 8191)), PTR_W'($urandom),
                    COL_W'($urandom), ROW_W'($urandom), $urandom, $urandom);
            3: update($urandom_range(0, ROWS - 1), $urandom_range(0, ROWS - 1),
                      $urandom, $urandom);
            default: load_start($urandom_range(0, ROWS), PTR_W'($urandom));
        endcase
    endtask

    initial
    begin
        rst_n        = 0;
        item_valid   = 0;
        mode         = MODE_ROW_START;
        address      = '0;
        row_pointer  = '0;
        col_index    = '0;
        row_index    = '0;
        value_real   = '0;
        value_imag   = '0;
        result_stall = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        tx_idle      = 0;
        rx_idle      = 0;
        words_sent   = 0;
        updates_sent = 0;
        for (int k = 0; k <= ROWS; k++)
            start_known[k] = 0;
        for (int k = 0; k < ENTRIES; k++)
            entry_known[k] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: top rows and slots, zero divisor, empty rows, ignored loads
        load_start(1022, 13'd4090);
        load_start(1023, 13'd4092);
        load_start(1024, 13'd4096);
        load_entry(4090, 1021, 32'h7FFF_FFFF, 32'h8000_0000);
        load_entry(4091, 1022, 32'h0, 32'h0);
        load_entry(4092, 1021, 32'h8000_0000, 32'h7FFF_FFFF);
        load_entry(4093, 1022, 32'h0030_0000, 32'hFFF0_0000);
        load_entry(4094, 1023, 32'h0010_0000, 32'h0);
        load_entry(4095, 1023, 32'h0, 32'h0010_0000);
        update(1023, 1022, 32'h0100_0000, 32'h0);
        update(1022, 1022, 32'h8000_0000, 32'h7FFF_FFFF);
        update(1023, 1022, 32'h7FFF_FFFF, 32'h8000_0000);
        update(1023, 1023, 32'h0, 32'h0);
        update(1022, 1023, 32'h0040_0000, 32'h0040_0000);
        load_start(0, 13'd5000);
        load_start(1, 13'h1FFF);
        update(0, 0, 32'h0010_0000, 32'h0);
        send(MODE_SPARE, 13'h1FFF, 13'h1FFF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_ROW_START, 13'h1FFF, 13'h0, 10'h0, 10'h0, 32'h0, 32'h0);
        send(MODE_ENTRY, 13'h1000, 13'h0, 10'h3FF, 10'h0, 32'h1234_5678, 32'h0);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle = (phase == 0) ? 23 : (phase == 1) ? 69 : 0;
            rx_idle <= (phase == 0) ? 69 : (phase == 1) ? 23 : 0;
            if (phase == 2)
                hold_left <= HOLD_CYCLES;
            while (words_sent < 30 + 360 * (phase + 1))
                if ($urandom_range(99) < 15)
                    noise_item();
                else
                    build_block();
        end
        item_valid <= 1'b0;

        while (words_waiting != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d words (%0d updates) over three idle patterns and a long output hold;",
                 words_sent, updates_sent);
        $display("%0d result words compared field by field.", words_checked);
        if (fail_count == 0 && words_waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/sics_pkg.sv
rtl/sparse_incomplete_cholesky_sweep.sv
verif/sics_checker.sv
verif/tb.sv
